[rtl/vpid_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpid_pkg
// Shared widths, register indexes and the saturation helper of the velocity
// pid unit.
// ----------------------------------------------------------------------------
package vpid_pkg;

	localparam int DW = 32;           // data width, signed q16.16
	localparam int FB = 16;           // fraction bits
	localparam int GW = 31;           // gain register width
	localparam int XW = 68;           // wide exact intermediate
	localparam int PW = 66;           // product width of the shared multiplier
	localparam int SW = PW - FB;      // product width after the fraction shift
	localparam int QW = 48;           // divider dividend and quotient width
	localparam int RW = 33;           // divider divisor width
	localparam int CW = FB + 1;       // filter coefficient width
	localparam int IW = 3;            // register index width

	typedef enum logic [IW-1:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_INTEG_GAIN  = 3'd1,
		REG_DERIV_GAIN  = 3'd2,
		REG_FILTER_TAU  = 3'd3,
		REG_CONTROL_MIN = 3'd4,
		REG_CONTROL_MAX = 3'd5
	} reg_idx_t;

	localparam logic signed [XW-1:0] SAT_HI = 68'sd2147483647;
	localparam logic signed [XW-1:0] SAT_LO = -68'sd2147483648;

	function automatic logic signed [DW-1:0] sat_dw(input logic signed [XW-1:0] x);
		logic signed [DW-1:0] r;
		if (x > SAT_HI) begin
			r = SAT_HI[DW-1:0];
		end else if (x < SAT_LO) begin
			r = SAT_LO[DW-1:0];
		end else begin
			r = x[DW-1:0];
		end
		return r;
	endfunction

endpackage

[rtl/vpid_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpid_in_if / vpid_out_if
// Valid/ready channels carrying one sample item in and one control item out.
// ----------------------------------------------------------------------------
interface vpid_in_if;
	logic                          valid;
	logic                          ready;
	logic                          sample_due;
	logic [vpid_pkg::DW-1:0]        elapsed_time;
	logic signed [vpid_pkg::DW-1:0] measured_speed;
	logic signed [vpid_pkg::DW-1:0] target_speed;

	modport source (output valid, sample_due, elapsed_time, measured_speed, target_speed,
		input ready);
	modport sink (input valid, sample_due, elapsed_time, measured_speed, target_speed,
		output ready);
endinterface

interface vpid_out_if;
	logic                          valid;
	logic                          ready;
	logic signed [vpid_pkg::DW-1:0] control_out;
	logic                          updated;

	modport source (output valid, control_out, updated, input ready);
	modport sink (input valid, control_out, updated, output ready);
endinterface

[rtl/velocity_pid_with_filtered_derivative_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// velocity_pid_with_filtered_derivative_unit
// Incremental pid in q16.16 with anti-windup and a low-pass filtered
// derivative, built around one shared multiplier and one serial divider.
// ----------------------------------------------------------------------------
// sequence: an item with sample_due clear gives its result in the cycle after
//   it is taken; with sample_due set, it runs four multiplier steps, three
//   serial divider passes, two filter multiplier steps and two update steps
// throughput: one item at a time, the next is taken once the result is gone
// reset: arst_n clears configuration, controller state, sequencer and output valid
// ----------------------------------------------------------------------------
module velocity_pid_with_filtered_derivative_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	vpid_in_if.sink                      in_ch,
	vpid_out_if.source                   out_ch,
	input  logic                         cfg_we,
	input  logic [vpid_pkg::IW-1:0]      cfg_idx,
	input  logic [vpid_pkg::DW-1:0]      cfg_wdata
);
	typedef enum logic [14:0] {
		S_IDLE = 15'b000000000000001,
		S_MP   = 15'b000000000000010,
		S_MK   = 15'b000000000000100,
		S_MI   = 15'b000000000001000,
		S_MD   = 15'b000000000010000,
		S_DS1  = 15'b000000000100000,
		S_DW1  = 15'b000000001000000,
		S_DS2  = 15'b000000010000000,
		S_DW2  = 15'b000000100000000,
		S_DS3  = 15'b000001000000000,
		S_DW3  = 15'b000010000000000,
		S_MF1  = 15'b000100000000000,
		S_MF2  = 15'b001000000000000,
		S_UPD1 = 15'b010000000000000,
		S_UPD2 = 15'b100000000000000
	} state_t;

	localparam int DW = vpid_pkg::DW;
	localparam int FB = vpid_pkg::FB;
	localparam int XW = vpid_pkg::XW;
	localparam int PW = vpid_pkg::PW;
	localparam int SW = vpid_pkg::SW;
	localparam int QW = vpid_pkg::QW;
	localparam int RW = vpid_pkg::RW;
	localparam int CW = vpid_pkg::CW;
	localparam int GW = vpid_pkg::GW;

	state_t st_q;

	// configuration
	logic [GW-1:0]        pg_q, ig_q, kd_q, tau_q;
	logic signed [DW-1:0] cmin_q, cmax_q;

	// controller state
	logic signed [DW-1:0] lc_q, le_q, oe_q, lfd_q;

	// per-item working registers
	logic [DW-1:0]        ts_q;
	logic signed [DW-1:0] e_q, p_q, i_q, deriv_q, filt_q;
	logic                 neg_q;
	logic [CW-1:0]        ca_q, cb_q;
	logic signed [SW-1:0] f1_q;

	// output register
	logic                 ov_q;
	logic signed [DW-1:0] ctl_q;
	logic                 upd_q;

	// shared multiplier
	logic signed [RW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod_q;
	logic signed [SW-1:0] sh;

	// divider
	logic                 div_start;
	logic [QW-1:0]        div_dvd;
	logic [RW-1:0]        div_dsr;
	logic                 div_done;
	logic [QW-1:0]        div_quo;

	logic signed [DW-1:0] de, d2, kits, kdd, integ, u, lo, hi;
	logic [DW-1:0]        kmag;
	logic signed [QW:0]   qs;
	logic [DW-1:0]        ts_in;
	logic                 in_acc;

	assign sh    = $signed(prod_q[PW-1:FB]);
	assign de    = vpid_pkg::sat_dw(XW'(e_q) - XW'(le_q));
	assign d2    = vpid_pkg::sat_dw(XW'(e_q) - (XW'(le_q) <<< 1) + XW'(oe_q));
	assign kits  = vpid_pkg::sat_dw(XW'(sh));
	assign kdd   = vpid_pkg::sat_dw(XW'(sh));
	assign kmag  = kdd[DW-1] ? (~kdd + 1'b1) : kdd;
	assign integ = vpid_pkg::sat_dw(XW'(sh));
	assign lo    = (cmin_q < cmax_q) ? cmin_q : cmax_q;
	assign hi    = (cmin_q < cmax_q) ? cmax_q : cmin_q;
	assign qs    = neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
	assign u     = vpid_pkg::sat_dw(XW'(lc_q) + XW'(p_q) + XW'(i_q) + XW'(filt_q));
	assign ts_in = (in_ch.elapsed_time == '0) ? DW'(1) : in_ch.elapsed_time;

	assign in_ch.ready = (st_q == S_IDLE) && !ov_q;
	assign in_acc      = in_ch.valid && in_ch.ready;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			S_MP: begin
				mul_a = {2'b0, pg_q};
				mul_b = RW'(de);
			end
			S_MK: begin
				mul_a = {1'b0, ts_q};
				mul_b = {2'b0, ig_q};
			end
			S_MI: begin
				mul_a = RW'(kits);
				mul_b = RW'(e_q);
			end
			S_MD: begin
				mul_a = {2'b0, kd_q};
				mul_b = RW'(d2);
			end
			S_MF1: begin
				mul_a = {{(RW-CW){1'b0}}, ca_q};
				mul_b = RW'(lfd_q);
			end
			S_MF2: begin
				mul_a = {{(RW-CW){1'b0}}, cb_q};
				mul_b = RW'(deriv_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_dsr   = {1'b0, ts_q};
		case (st_q)
			S_DS1: begin
				div_start = 1'b1;
				div_dvd   = {kmag, {FB{1'b0}}};
				div_dsr   = {1'b0, ts_q};
			end
			S_DS2: begin
				div_start = 1'b1;
				div_dvd   = {1'b0, tau_q, {FB{1'b0}}};
				div_dsr   = {2'b0, tau_q} + {1'b0, ts_q};
			end
			S_DS3: begin
				div_start = 1'b1;
				div_dvd   = {ts_q, {FB{1'b0}}};
				div_dsr   = {2'b0, tau_q} + {1'b0, ts_q};
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	vpid_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_quo)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pg_q   <= '0;
			ig_q   <= '0;
			kd_q   <= '0;
			tau_q  <= '0;
			cmin_q <= '0;
			cmax_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				vpid_pkg::REG_PROP_GAIN:   pg_q   <= cfg_wdata[GW-1:0];
				vpid_pkg::REG_INTEG_GAIN:  ig_q   <= cfg_wdata[GW-1:0];
				vpid_pkg::REG_DERIV_GAIN:  kd_q   <= cfg_wdata[GW-1:0];
				vpid_pkg::REG_FILTER_TAU:  tau_q  <= cfg_wdata[GW-1:0];
				vpid_pkg::REG_CONTROL_MIN: cmin_q <= $signed(cfg_wdata);
				vpid_pkg::REG_CONTROL_MAX: cmax_q <= $signed(cfg_wdata);
				default: begin
				end
			endcase
		end
	end

	// sequencer, controller state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_IDLE;
			ov_q  <= 1'b0;
			lc_q  <= '0;
			le_q  <= '0;
			oe_q  <= '0;
			lfd_q <= '0;
		end else begin
			if (ov_q && out_ch.ready) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_ch.sample_due) begin
							st_q <= S_MP;
						end else begin
							ov_q <= 1'b1;
						end
					end
				end
				S_MP:  st_q <= S_MK;
				S_MK:  st_q <= S_MI;
				S_MI:  st_q <= S_MD;
				S_MD:  st_q <= S_DS1;
				S_DS1: st_q <= S_DW1;
				S_DW1: begin
					if (div_done) begin
						st_q <= S_DS2;
					end
				end
				S_DS2: st_q <= S_DW2;
				S_DW2: begin
					if (div_done) begin
						st_q <= S_DS3;
					end
				end
				S_DS3: st_q <= S_DW3;
				S_DW3: begin
					if (div_done) begin
						st_q <= S_MF1;
					end
				end
				S_MF1:  st_q <= S_MF2;
				S_MF2:  st_q <= S_UPD1;
				S_UPD1: st_q <= S_UPD2;
				S_UPD2: begin
					lc_q  <= u;
					oe_q  <= le_q;
					le_q  <= e_q;
					lfd_q <= filt_q;
					ov_q  <= 1'b1;
					st_q  <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (st_q)
			S_IDLE: begin
				if (in_acc) begin
					ts_q  <= ts_in;
					e_q   <= vpid_pkg::sat_dw(XW'(in_ch.target_speed) -
						XW'(in_ch.measured_speed));
					ctl_q <= lc_q;
					upd_q <= 1'b0;
				end
			end
			S_MK: p_q <= vpid_pkg::sat_dw(XW'(sh));
			S_MD: i_q <= (integ < lo || integ > hi) ? '0 : integ;
			S_DS1: neg_q <= kdd[DW-1];
			S_DW1: begin
				if (div_done) begin
					deriv_q <= vpid_pkg::sat_dw(XW'(qs));
				end
			end
			S_DW2: begin
				if (div_done) begin
					ca_q <= div_quo[CW-1:0];
				end
			end
			S_DW3: begin
				if (div_done) begin
					cb_q <= div_quo[CW-1:0];
				end
			end
			S_MF2: f1_q <= sh;
			S_UPD1: filt_q <= vpid_pkg::sat_dw(XW'(f1_q) + XW'(sh));
			S_UPD2: begin
				ctl_q <= u;
				upd_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign out_ch.valid       = ov_q;
	assign out_ch.control_out = ctl_q;
	assign out_ch.updated     = upd_q;
endmodule

[rtl/vpid_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpid_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vpid_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [vpid_pkg::QW-1:0]     dividend,
	input  logic [vpid_pkg::RW-1:0]     divisor,
	output logic                        done,
	output logic [vpid_pkg::QW-1:0]     quotient
);
	localparam int NW = $clog2(vpid_pkg::QW);
	localparam logic [NW-1:0] LAST = NW'(vpid_pkg::QW - 1);

	logic                      busy_q;
	logic                      done_q;
	logic [NW-1:0]             cnt_q;
	logic [vpid_pkg::QW-1:0]   dvd_q;
	logic [vpid_pkg::QW-1:0]   quo_q;
	logic [vpid_pkg::RW-1:0]   dsr_q;
	logic [vpid_pkg::RW-1:0]   rem_q;
	logic [vpid_pkg::RW:0]     rem_sh;
	logic [vpid_pkg::RW+1:0]   diff;

	assign rem_sh = {rem_q, dvd_q[vpid_pkg::QW-1]};
	assign diff   = {1'b0, rem_sh} - {2'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[vpid_pkg::QW-2:0], 1'b0};
			if (!diff[vpid_pkg::RW+1]) begin
				rem_q <= diff[vpid_pkg::RW-1:0];
				quo_q <= {quo_q[vpid_pkg::QW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[vpid_pkg::RW-1:0];
				quo_q <= {quo_q[vpid_pkg::QW-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
